// ===== rtl/voltage_current_protection_relay_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the voltage/current protection relay.
// Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VOLTAGE_CURRENT_PROTECTION_RELAY_DEFINES_SVH
`define VOLTAGE_CURRENT_PROTECTION_RELAY_DEFINES_SVH

`ifndef SYNTH
// check gated off while reset is asserted
`define VCPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also runs through reset
`define VCPR_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VCPR_ASSERT(lbl, clk, rst_n, prop, msg)
`define VCPR_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/vcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// vcpr_pkg
// Codes and reset constants shared by the protection relay files.
// ----------------------------------------------------------------------------
`default_nettype none

package vcpr_pkg;

    localparam int NUM_CH       = 4;
    localparam int CH_VOLT      = 0;
    localparam int CFG_IDX_BITS = 3;

    // register reset values
    localparam int RST_OV_LEVEL = 2000;
    localparam int RST_UV_LEVEL = 1000;
    localparam int RST_FC_LEVEL = 80;
    localparam int RST_SC_LEVEL = 50;
    localparam int RST_OV_TIME  = 100;
    localparam int RST_UV_TIME  = 10;
    localparam int RST_FC_TIME  = 20;
    localparam int RST_SC_TIME  = 1000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OV_LEVEL = 3'd0,
        REG_UV_LEVEL = 3'd1,
        REG_FC_LEVEL = 3'd2,
        REG_SC_LEVEL = 3'd3,
        REG_OV_TIME  = 3'd4,
        REG_UV_TIME  = 3'd5,
        REG_FC_TIME  = 3'd6,
        REG_SC_TIME  = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        CAUSE_NONE = 3'd0,
        CAUSE_OV   = 3'd1,
        CAUSE_UV   = 3'd2,
        CAUSE_FAST = 3'd3,
        CAUSE_SLOW = 3'd4
    } t_cause;

    typedef enum logic [1:0] {
        PHASE_NONE = 2'd0,
        PHASE_U    = 2'd1,
        PHASE_V    = 2'd2,
        PHASE_W    = 2'd3
    } t_phase;

endpackage

`default_nettype wire

// ===== rtl/vcpr_in_if.sv =====
// ----------------------------------------------------------------------------
// vcpr_in_if
// Sample set channel: one voltage and three phase currents per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface vcpr_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] voltage_sample;
    logic [SAMPLE_BITS-1:0] current_u_sample;
    logic [SAMPLE_BITS-1:0] current_v_sample;
    logic [SAMPLE_BITS-1:0] current_w_sample;

    modport source (
        output valid, voltage_sample, current_u_sample, current_v_sample,
               current_w_sample,
        input  ready
    );
    modport sink (
        input  valid, voltage_sample, current_u_sample, current_v_sample,
               current_w_sample,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/vcpr_out_if.sv =====
// ----------------------------------------------------------------------------
// vcpr_out_if
// Result channel: averages and trip report per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface vcpr_out_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] avg_voltage;
    logic [SAMPLE_BITS-1:0] avg_current_u;
    logic [SAMPLE_BITS-1:0] avg_current_v;
    logic [SAMPLE_BITS-1:0] avg_current_w;
    logic                   tripped;
    logic [2:0]             trip_cause;
    logic [1:0]             trip_phase;

    modport source (
        output valid, avg_voltage, avg_current_u, avg_current_v, avg_current_w,
               tripped, trip_cause, trip_phase,
        input  ready
    );
    modport sink (
        input  valid, avg_voltage, avg_current_u, avg_current_v, avg_current_w,
               tripped, trip_cause, trip_phase,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/voltage_current_protection_relay.sv =====
// Pipeline: an accepted input beat passes the lane average registers, then the merge result register.
// Throughput: one sample set per cycle while the output is not stalled; the limit is
//   the trip counter update in the merge stage, which every set needs from the set before it.
// Reset: synchronous, active low; clears histories, trip counters and valid
//   flags, and loads the register defaults.
// ----------------------------------------------------------------------------
// voltage_current_protection_relay
// Four averaging lanes (voltage, U, V, W) feed a merge stage that runs the
// leaky over/under-voltage and fast/slow over-current trip counters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voltage_current_protection_relay_defines.svh"

module voltage_current_protection_relay #(
    parameter int WINDOW      = 4,
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16,
    localparam int CFG_BITS   = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    vcpr_in_if.sink                                i_in,
    vcpr_out_if.source                             o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [vcpr_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]               i_cfg_data
);
    import vcpr_pkg::*;

    // ---------------- configuration registers ----------------
    logic [SAMPLE_BITS-1:0] r_ov_level, r_uv_level, r_fc_level, r_sc_level;
    logic [COUNT_BITS-1:0]  r_ov_time, r_uv_time, r_fc_time, r_sc_time;
    logic [SAMPLE_BITS-1:0] cfg_level;
    logic [COUNT_BITS-1:0]  cfg_time;

    assign cfg_level = i_cfg_data[SAMPLE_BITS-1:0];
    assign cfg_time  = i_cfg_data[COUNT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov_level <= SAMPLE_BITS'(RST_OV_LEVEL);
            r_uv_level <= SAMPLE_BITS'(RST_UV_LEVEL);
            r_fc_level <= SAMPLE_BITS'(RST_FC_LEVEL);
            r_sc_level <= SAMPLE_BITS'(RST_SC_LEVEL);
            r_ov_time  <= COUNT_BITS'(RST_OV_TIME);
            r_uv_time  <= COUNT_BITS'(RST_UV_TIME);
            r_fc_time  <= COUNT_BITS'(RST_FC_TIME);
            r_sc_time  <= COUNT_BITS'(RST_SC_TIME);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_OV_LEVEL: r_ov_level <= cfg_level;
                REG_UV_LEVEL: r_uv_level <= cfg_level;
                REG_FC_LEVEL: r_fc_level <= cfg_level;
                REG_SC_LEVEL: r_sc_level <= cfg_level;
                REG_OV_TIME:  r_ov_time  <= cfg_time;
                REG_UV_TIME:  r_uv_time  <= cfg_time;
                REG_FC_TIME:  r_fc_time  <= cfg_time;
                REG_SC_TIME:  r_sc_time  <= cfg_time;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // stage 1 = lane averages, stage 2 = merge/result register.
    // stage 2 advances when the output is empty or its beat is taken.
    logic r_s1_valid, n_s1_valid;
    logic r_out_valid, n_out_valid;
    logic adv;
    logic load1;
    logic load2;

    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || adv;
    assign load1      = i_in.valid && i_in.ready;
    assign load2      = r_s1_valid && adv;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (load1) n_s1_valid = 1'b1;
        else if (load2) n_s1_valid = 1'b0;

        n_out_valid = r_out_valid;
        if (load2) n_out_valid = 1'b1;
        else if (o_out.ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // ---------------- averaging lanes ----------------
    logic [SAMPLE_BITS-1:0] samples [NUM_CH];
    logic [SAMPLE_BITS-1:0] lane_avg [NUM_CH];
    logic [SAMPLE_BITS-1:0] res_avg [NUM_CH];
    logic                   res_tripped;
    t_cause                 res_cause;
    t_phase                 res_phase;

    assign samples[0] = i_in.voltage_sample;
    assign samples[1] = i_in.current_u_sample;
    assign samples[2] = i_in.current_v_sample;
    assign samples[3] = i_in.current_w_sample;

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        vcpr_lane #(
            .WINDOW      (WINDOW),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (load1),
            .i_sample (samples[g]),
            .o_avg    (lane_avg[g])
        );
    end

    // ---------------- merge stage ----------------
    vcpr_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load2),
        .i_avg      (lane_avg),
        .i_ov_level (r_ov_level),
        .i_uv_level (r_uv_level),
        .i_fc_level (r_fc_level),
        .i_sc_level (r_sc_level),
        .i_ov_time  (r_ov_time),
        .i_uv_time  (r_uv_time),
        .i_fc_time  (r_fc_time),
        .i_sc_time  (r_sc_time),
        .o_avg      (res_avg),
        .o_tripped  (res_tripped),
        .o_cause    (res_cause),
        .o_phase    (res_phase)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.avg_voltage   = res_avg[0];
    assign o_out.avg_current_u = res_avg[1];
    assign o_out.avg_current_v = res_avg[2];
    assign o_out.avg_current_w = res_avg[3];
    assign o_out.tripped       = res_tripped;
    assign o_out.trip_cause    = res_cause;
    assign o_out.trip_phase    = res_phase;

    // ---------------- assertions ----------------
    `VCPR_ASSERT_NR(a_rst_clears_out, i_clk, !i_rst_n |=> !o_out.valid, "output valid after reset")
    `VCPR_ASSERT(a_stall_blocks_in, i_clk, i_rst_n, (r_s1_valid && o_out.valid && !o_out.ready) |-> !i_in.ready, "input taken while pipeline full")
    `VCPR_ASSERT(a_trip_flag, i_clk, i_rst_n, o_out.valid |-> (o_out.tripped == (res_cause != CAUSE_NONE)), "trip flag disagrees with cause")
    `VCPR_ASSERT(a_volt_no_phase, i_clk, i_rst_n, (o_out.valid && (res_cause == CAUSE_NONE || res_cause == CAUSE_OV || res_cause == CAUSE_UV)) |-> (res_phase == PHASE_NONE), "phase set without current trip")

endmodule

`default_nettype wire

// ===== rtl/vcpr_lane.sv =====
// ----------------------------------------------------------------------------
// vcpr_lane
// One channel: sample history and WINDOW-tap moving average, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vcpr_lane #(
    parameter int WINDOW      = 4,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic      [SAMPLE_BITS-1:0] o_avg
);
    localparam int HIST_DEPTH = WINDOW - 1;
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW);
    // divide by WINDOW as multiply by ceil(2^K / WINDOW), exact for SUM_BITS inputs
    localparam int SHIFT      = SUM_BITS + $clog2(WINDOW);
    localparam int MUL_BITS   = SHIFT + 1;
    localparam int PROD_BITS  = SUM_BITS + MUL_BITS;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

    logic [SAMPLE_BITS-1:0] r_hist [HIST_DEPTH];
    logic [SAMPLE_BITS-1:0] r_avg;
    logic [SUM_BITS-1:0]    sum;
    logic [PROD_BITS-1:0]   prod;

    always_comb begin
        sum = SUM_BITS'(i_sample);
        for (int k = 0; k < HIST_DEPTH; k++) begin
            sum = sum + SUM_BITS'(r_hist[k]);
        end
        prod = PROD_BITS'(sum) * PROD_BITS'(MUL_BITS'(RECIP));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_load) begin
            r_hist[0] <= i_sample;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_avg <= prod[SHIFT +: SAMPLE_BITS];
        end
    end

    assign o_avg = r_avg;

endmodule

`default_nettype wire

// ===== rtl/vcpr_merge.sv =====
// ----------------------------------------------------------------------------
// vcpr_merge
// Merges lane averages: leaky trip counters, trip decision, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vcpr_merge #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic [SAMPLE_BITS-1:0] i_avg [vcpr_pkg::NUM_CH],
    input  wire logic [SAMPLE_BITS-1:0] i_ov_level,
    input  wire logic [SAMPLE_BITS-1:0] i_uv_level,
    input  wire logic [SAMPLE_BITS-1:0] i_fc_level,
    input  wire logic [SAMPLE_BITS-1:0] i_sc_level,
    input  wire logic [COUNT_BITS-1:0]  i_ov_time,
    input  wire logic [COUNT_BITS-1:0]  i_uv_time,
    input  wire logic [COUNT_BITS-1:0]  i_fc_time,
    input  wire logic [COUNT_BITS-1:0]  i_sc_time,
    output logic      [SAMPLE_BITS-1:0] o_avg [vcpr_pkg::NUM_CH],
    output logic                        o_tripped,
    output vcpr_pkg::t_cause            o_cause,
    output vcpr_pkg::t_phase            o_phase
);
    import vcpr_pkg::*;

    // up, down toward zero, else hold; saturates at all ones
    function automatic logic [COUNT_BITS-1:0] leak(
        input logic [COUNT_BITS-1:0] cnt,
        input logic                  up,
        input logic                  dn
    );
        logic [COUNT_BITS-1:0] res;
        res = cnt;
        if (up) begin
            if (cnt != '1) res = cnt + 1'b1;
        end else if (dn && (cnt != '0)) begin
            res = cnt - 1'b1;
        end
        return res;
    endfunction

    logic [COUNT_BITS-1:0]  r_ov_cnt, n_ov_cnt;
    logic [COUNT_BITS-1:0]  r_uv_cnt, n_uv_cnt;
    logic [COUNT_BITS-1:0]  r_fc_cnt, n_fc_cnt;
    logic [COUNT_BITS-1:0]  r_sc_cnt, n_sc_cnt;
    logic [SAMPLE_BITS-1:0] r_avg [NUM_CH];
    logic                   r_tripped;
    t_cause                 r_cause, n_cause;
    t_phase                 r_phase, n_phase;
    logic [SAMPLE_BITS-1:0] av;

    always_comb begin
        av       = i_avg[CH_VOLT];
        n_cause  = CAUSE_NONE;
        n_phase  = PHASE_NONE;
        n_uv_cnt = r_uv_cnt;
        n_fc_cnt = r_fc_cnt;
        n_sc_cnt = r_sc_cnt;

        n_ov_cnt = leak(r_ov_cnt, av > i_ov_level, av < i_ov_level);
        if (n_ov_cnt >= i_ov_time) begin
            n_cause = CAUSE_OV;
        end else begin
            n_uv_cnt = leak(r_uv_cnt, av < i_uv_level, av > i_uv_level);
            if (n_uv_cnt >= i_uv_time) n_cause = CAUSE_UV;
        end

        // phases U, V, W in order; stop at the first trip
        for (int ch = 1; ch < NUM_CH; ch++) begin
            if (n_cause == CAUSE_NONE) begin
                n_fc_cnt = leak(n_fc_cnt, i_avg[ch] > i_fc_level,
                                i_avg[ch] < i_fc_level);
                if (n_fc_cnt >= i_fc_time) begin
                    n_cause = CAUSE_FAST;
                    n_phase = t_phase'(2'(ch));
                end else begin
                    n_sc_cnt = leak(n_sc_cnt, i_avg[ch] > i_sc_level,
                                    i_avg[ch] < i_sc_level);
                    if (n_sc_cnt >= i_sc_time) begin
                        n_cause = CAUSE_SLOW;
                        n_phase = t_phase'(2'(ch));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov_cnt <= '0;
            r_uv_cnt <= '0;
            r_fc_cnt <= '0;
            r_sc_cnt <= '0;
        end else if (i_load) begin
            r_ov_cnt <= n_ov_cnt;
            r_uv_cnt <= n_uv_cnt;
            r_fc_cnt <= n_fc_cnt;
            r_sc_cnt <= n_sc_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_avg     <= i_avg;
            r_tripped <= (n_cause != CAUSE_NONE);
            r_cause   <= n_cause;
            r_phase   <= n_phase;
        end
    end

    assign o_avg     = r_avg;
    assign o_tripped = r_tripped;
    assign o_cause   = r_cause;
    assign o_phase   = r_phase;

endmodule

`default_nettype wire

// ===== test/tb_voltage_current_protection_relay.sv =====
// ----------------------------------------------------------------------------
// tb_voltage_current_protection_relay
// Self-checking bench for the protection relay. Sample sets go in over the
// valid/ready input channel, and a built-in predictor of the averaging lanes
// and the four leaky trip counters queues the expected result for every
// accepted beat. Each result beat is compared field by field with the oldest
// expectation. Directed cases cover reset defaults, full scale, zero trip
// time and phase order. Random phases then reprogram every register and
// drive threshold-hugging bursts, with random stalls on either side in some phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voltage_current_protection_relay;
    import vcpr_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;
    localparam int CFG_BITS    = 16;
    localparam int WINDOW      = 4;
    localparam int HIST_DEPTH  = WINDOW - 1;
    localparam int MAX_SAMPLE  = (1 << SAMPLE_BITS) - 1;
    localparam int MAX_TIME    = (1 << COUNT_BITS) - 1;

    // lane order inside a sample set; voltage lane comes from the package
    localparam int LANE_U = CH_VOLT + 1;
    localparam int LANE_V = CH_VOLT + 2;
    localparam int LANE_W = CH_VOLT + 3;
    localparam t_phase LANE_PHASE [NUM_CH] = '{PHASE_NONE, PHASE_U, PHASE_V, PHASE_W};

    typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0] t_sample_set;

    typedef struct packed {
        logic [NUM_CH-1:0][SAMPLE_BITS-1:0] avg;
        logic                               tripped;
        t_cause                             cause;
        t_phase                             phase;
    } t_relay_result;

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block under test
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    vcpr_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    vcpr_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]     i_cfg_data;

    voltage_current_protection_relay #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (sample_ch),
        .o_out       (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: own copy of the registers, histories and counters
    // ------------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] ov_level, uv_level, fast_level, slow_level;
    logic [COUNT_BITS-1:0]  ov_time, uv_time, fast_time, slow_time;
    logic [SAMPLE_BITS-1:0] lane_hist [NUM_CH][HIST_DEPTH];
    logic [COUNT_BITS-1:0]  ov_count, uv_count, fast_count, slow_count;

    t_relay_result expected_results [$];
    int            error_count = 0;

    // per-beat idle limits, changed by the tests; 0 means no idling
    int unsigned send_gap_max   = 16;
    int unsigned sink_stall_max = 16;

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // leaky counter: up wins, down stops at zero, saturates at all ones
    function automatic logic [COUNT_BITS-1:0] leaked(input logic [COUNT_BITS-1:0] c,
                                                     input bit up, input bit down);
        if (up) begin
            return (&c) ? c : c + 1'b1;
        end
        if (down && c != '0) begin
            return c - 1'b1;
        end
        return c;
    endfunction

    function automatic void reset_relay_model();
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                lane_hist[ch][k] = '0;
            end
        end
        ov_count   = '0;
        uv_count   = '0;
        fast_count = '0;
        slow_count = '0;
        ov_level   = SAMPLE_BITS'(RST_OV_LEVEL);
        uv_level   = SAMPLE_BITS'(RST_UV_LEVEL);
        fast_level = SAMPLE_BITS'(RST_FC_LEVEL);
        slow_level = SAMPLE_BITS'(RST_SC_LEVEL);
        ov_time    = COUNT_BITS'(RST_OV_TIME);
        uv_time    = COUNT_BITS'(RST_UV_TIME);
        fast_time  = COUNT_BITS'(RST_FC_TIME);
        slow_time  = COUNT_BITS'(RST_SC_TIME);
    endfunction

    // levels keep the low sample bits, times the low count bits
    function automatic void apply_reg_write(input t_reg_idx idx,
                                            input logic [CFG_BITS-1:0] data);
        case (idx)
            REG_OV_LEVEL: ov_level   = data[SAMPLE_BITS-1:0];
            REG_UV_LEVEL: uv_level   = data[SAMPLE_BITS-1:0];
            REG_FC_LEVEL: fast_level = data[SAMPLE_BITS-1:0];
            REG_SC_LEVEL: slow_level = data[SAMPLE_BITS-1:0];
            REG_OV_TIME:  ov_time    = data[COUNT_BITS-1:0];
            REG_UV_TIME:  uv_time    = data[COUNT_BITS-1:0];
            REG_FC_TIME:  fast_time  = data[COUNT_BITS-1:0];
            REG_SC_TIME:  slow_time  = data[COUNT_BITS-1:0];
            default: ;
        endcase
    endfunction

    // One accepted sample set: average every lane, then walk the counters in
    // priority order (over-voltage, under-voltage, then fast/slow per phase
    // U, V, W). Evaluation stops at the first counter at its trip time, so
    // later counters keep their value for this beat.
    function automatic t_relay_result predict_trip(input t_sample_set smp);
        t_relay_result          r;
        logic [SAMPLE_BITS+1:0] sum;
        logic [SAMPLE_BITS-1:0] a;

        r       = '0;
        r.cause = CAUSE_NONE;
        r.phase = PHASE_NONE;

        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum = smp[ch];
            for (int k = 0; k < HIST_DEPTH; k++) begin
                sum = sum + lane_hist[ch][k];
            end
            for (int k = HIST_DEPTH - 1; k > 0; k--) begin
                lane_hist[ch][k] = lane_hist[ch][k-1];
            end
            lane_hist[ch][0] = smp[ch];
            r.avg[ch] = SAMPLE_BITS'(sum / WINDOW);
        end

        a = r.avg[CH_VOLT];
        ov_count = leaked(ov_count, a > ov_level, a < ov_level);
        if (ov_count >= ov_time) begin
            r.cause = CAUSE_OV;
        end else begin
            uv_count = leaked(uv_count, a < uv_level, a > uv_level);
            if (uv_count >= uv_time) begin
                r.cause = CAUSE_UV;
            end
        end

        // both current counters are shared by the three phases
        for (int ch = LANE_U; ch < NUM_CH; ch++) begin
            if (r.cause == CAUSE_NONE) begin
                a = r.avg[ch];
                fast_count = leaked(fast_count, a > fast_level, a < fast_level);
                if (fast_count >= fast_time) begin
                    r.cause = CAUSE_FAST;
                    r.phase = LANE_PHASE[ch];
                end else begin
                    slow_count = leaked(slow_count, a > slow_level, a < slow_level);
                    if (slow_count >= slow_time) begin
                        r.cause = CAUSE_SLOW;
                        r.phase = LANE_PHASE[ch];
                    end
                end
            end
        end

        r.tripped = (r.cause != CAUSE_NONE);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge. Register writes and
    // accepted input beats update the predictor, result beats are checked
    // against the oldest queued expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : relay_monitor
        t_relay_result got;
        t_relay_result want;
        t_sample_set   smp;

        if (!i_rst_n) begin
            reset_relay_model();
        end else begin
            if (i_cfg_we) begin
                apply_reg_write(t_reg_idx'(i_cfg_index), i_cfg_data);
            end

            if (sample_ch.valid && sample_ch.ready) begin
                smp[CH_VOLT] = sample_ch.voltage_sample;
                smp[LANE_U]  = sample_ch.current_u_sample;
                smp[LANE_V]  = sample_ch.current_v_sample;
                smp[LANE_W]  = sample_ch.current_w_sample;
                expected_results.push_back(predict_trip(smp));
            end

            if (result_ch.valid && result_ch.ready) begin
                got.avg[CH_VOLT] = result_ch.avg_voltage;
                got.avg[LANE_U]  = result_ch.avg_current_u;
                got.avg[LANE_V]  = result_ch.avg_current_v;
                got.avg[LANE_W]  = result_ch.avg_current_w;
                got.tripped      = result_ch.tripped;
                got.cause        = t_cause'(result_ch.trip_cause);
                got.phase        = t_phase'(result_ch.trip_phase);

                if (expected_results.size() == 0) begin
                    report_error("result beat with no sample set pending");
                end else begin
                    want = expected_results.pop_front();
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        if (got.avg[ch] !== want.avg[ch]) begin
                            report_error($sformatf("average lane %0d: got %0d, expected %0d",
                                                   ch, got.avg[ch], want.avg[ch]));
                        end
                    end
                    if (got.tripped !== want.tripped) begin
                        report_error($sformatf("tripped: got %b, expected %b",
                                               got.tripped, want.tripped));
                    end
                    if (got.cause !== want.cause) begin
                        report_error($sformatf("trip_cause: got %0d, expected %0d",
                                               got.cause, want.cause));
                    end
                    if (got.phase !== want.phase) begin
                        report_error($sformatf("trip_phase: got %0d, expected %0d",
                                               got.phase, want.phase));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: random stall before each beat, ready held while waiting
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;

        result_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(sink_stall_max, 0);
            if (stall != 0) begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(result_ch.valid && result_ch.ready));
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers: all called at a falling edge, return at a falling edge
    // ------------------------------------------------------------------------

    // Valid stays high on return so back-to-back beats need no toggle;
    // the next call or drain_results decides what happens to it.
    task automatic send_sample(input t_sample_set s);
        int unsigned gap;

        gap = $urandom_range(send_gap_max, 0);
        if (gap != 0) begin
            sample_ch.valid            = 1'b0;
            // junk payload while idle must be ignored
            sample_ch.voltage_sample   = SAMPLE_BITS'($urandom);
            sample_ch.current_u_sample = SAMPLE_BITS'($urandom);
            sample_ch.current_v_sample = SAMPLE_BITS'($urandom);
            sample_ch.current_w_sample = SAMPLE_BITS'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        sample_ch.valid            = 1'b1;
        sample_ch.voltage_sample   = s[CH_VOLT];
        sample_ch.current_u_sample = s[LANE_U];
        sample_ch.current_v_sample = s[LANE_V];
        sample_ch.current_w_sample = s[LANE_W];
        do @(posedge i_clk); while (!sample_ch.ready);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every outstanding result beat
    task automatic drain_results();
        sample_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_BITS-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // reset values, with junk in the unused upper bits of the level registers
    task automatic load_defaults();
        write_reg(REG_OV_LEVEL, CFG_BITS'(RST_OV_LEVEL) | 16'hF000);
        write_reg(REG_UV_LEVEL, CFG_BITS'(RST_UV_LEVEL) | 16'hA000);
        write_reg(REG_FC_LEVEL, CFG_BITS'(RST_FC_LEVEL) | 16'h5000);
        write_reg(REG_SC_LEVEL, CFG_BITS'(RST_SC_LEVEL) | 16'h9000);
        write_reg(REG_OV_TIME,  CFG_BITS'(RST_OV_TIME));
        write_reg(REG_UV_TIME,  CFG_BITS'(RST_UV_TIME));
        write_reg(REG_FC_TIME,  CFG_BITS'(RST_FC_TIME));
        write_reg(REG_SC_TIME,  CFG_BITS'(RST_SC_TIME));
    endtask

    function automatic t_sample_set make_set(input int volt, input int iu,
                                             input int iv, input int iw);
        t_sample_set s;
        s[CH_VOLT] = SAMPLE_BITS'(volt);
        s[LANE_U]  = SAMPLE_BITS'(iu);
        s[LANE_V]  = SAMPLE_BITS'(iv);
        s[LANE_W]  = SAMPLE_BITS'(iw);
        return s;
    endfunction

    function automatic int clamp_sample(input int v);
        return (v < 0) ? 0 : ((v > MAX_SAMPLE) ? MAX_SAMPLE : v);
    endfunction

    // Burst base for one lane: half the time near or exactly on one of the two
    // levels that lane is compared against, so counters move both ways
    // and the equality hold gets exercised.
    function automatic int pick_base(input int lvl_a, input int lvl_b);
        int lvl;
        lvl = $urandom_range(1, 0) ? lvl_a : lvl_b;
        case ($urandom_range(3, 0))
            0:       return $urandom_range(MAX_SAMPLE, 0);
            1:       return clamp_sample(lvl + int'($urandom_range(16, 0)) - 8);
            2:       return lvl;
            default: return $urandom_range(1, 0) ? MAX_SAMPLE : 0;
        endcase
    endfunction

    // mostly short trip times so trips actually happen; rarely zero or huge
    function automatic logic [CFG_BITS-1:0] pick_trip_time();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return CFG_BITS'($urandom_range(MAX_TIME, 1));
            default: return CFG_BITS'($urandom_range(40, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // All-zero input under reset settings: voltage below the under-voltage
    // level, so that counter trips on the tenth beat and stays tripped.
    task automatic test_default_settings();
        repeat (11) send_sample(make_set(0, 0, 0, 0));
        drain_results();
    endtask

    // full scale on every lane, then alternating bit patterns
    task automatic test_full_scale();
        repeat (4) send_sample(make_set(MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE));
        send_sample(make_set('hAAA, 'h555, 'hAAA, 'h555));
        send_sample(make_set('h555, 'hAAA, 'h555, 'hAAA));
        drain_results();
    endtask

    // A trip time of zero trips at the first evaluation of that counter.
    task automatic test_zero_trip_time();
        write_reg(REG_UV_TIME, CFG_BITS'(MAX_TIME));
        write_reg(REG_FC_TIME, '0);
        repeat (3) send_sample(make_set(1500, 10, 2000, 4095));
        drain_results();
        write_reg(REG_OV_TIME, '0);
        repeat (2) send_sample(make_set(1500, 10, 2000, 4095));
        drain_results();
        load_defaults();
    endtask

    // Shared slow counter crossing its time on phase W, then on phase V.
    // The fast level sits at full scale so the fast counter never rises.
    task automatic test_phase_order();
        write_reg(REG_OV_TIME, CFG_BITS'(MAX_TIME));
        write_reg(REG_UV_TIME, CFG_BITS'(MAX_TIME));
        write_reg(REG_FC_LEVEL, CFG_BITS'(MAX_SAMPLE));
        write_reg(REG_SC_LEVEL, 16'd100);
        write_reg(REG_SC_TIME, 16'd3);
        repeat (6) send_sample(make_set(1500, 100, 100, 600));
        repeat (3) send_sample(make_set(1500, 0, 0, 0));
        repeat (6) send_sample(make_set(1500, 100, 600, 100));
        drain_results();
        load_defaults();
    endtask

    task automatic run_burst(input int n_items);
        int          base [NUM_CH];
        int          spread;
        t_sample_set s;

        base[CH_VOLT] = pick_base(ov_level, uv_level);
        for (int ch = LANE_U; ch < NUM_CH; ch++) begin
            base[ch] = pick_base(fast_level, slow_level);
        end
        case ($urandom_range(2, 0))
            0:       spread = 0;
            1:       spread = 2;
            default: spread = 40;
        endcase

        repeat (n_items) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if ($urandom_range(9, 0) == 0) begin
                    s[ch] = SAMPLE_BITS'($urandom);
                end else begin
                    s[ch] = SAMPLE_BITS'(clamp_sample(base[ch] - spread +
                                         int'($urandom_range(2 * spread, 0))));
                end
            end
            send_sample(s);
        end
    endtask

    // Phases of random settings, the first two at the extremes. Levels in the
    // later phases get random upper bits, which the block must drop.
    task automatic test_random_settings();
        int sent;

        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            if (ph == 0) begin
                write_reg(REG_OV_LEVEL, '0);
                write_reg(REG_UV_LEVEL, '0);
                write_reg(REG_FC_LEVEL, '0);
                write_reg(REG_SC_LEVEL, '0);
                write_reg(REG_OV_TIME,  16'd1);
                write_reg(REG_UV_TIME,  16'd1);
                write_reg(REG_FC_TIME,  16'd1);
                write_reg(REG_SC_TIME,  16'd1);
            end else if (ph == 1) begin
                write_reg(REG_OV_LEVEL, CFG_BITS'(MAX_SAMPLE));
                write_reg(REG_UV_LEVEL, CFG_BITS'(MAX_SAMPLE));
                write_reg(REG_FC_LEVEL, CFG_BITS'(MAX_SAMPLE));
                write_reg(REG_SC_LEVEL, CFG_BITS'(MAX_SAMPLE));
                write_reg(REG_OV_TIME,  CFG_BITS'(MAX_TIME));
                write_reg(REG_UV_TIME,  CFG_BITS'(MAX_TIME));
                write_reg(REG_FC_TIME,  CFG_BITS'(MAX_TIME));
                write_reg(REG_SC_TIME,  CFG_BITS'(MAX_TIME));
            end else begin
                write_reg(REG_OV_LEVEL, CFG_BITS'($urandom));
                write_reg(REG_UV_LEVEL, CFG_BITS'($urandom));
                write_reg(REG_FC_LEVEL, CFG_BITS'($urandom));
                write_reg(REG_SC_LEVEL, CFG_BITS'($urandom));
                write_reg(REG_OV_TIME,  pick_trip_time());
                write_reg(REG_UV_TIME,  pick_trip_time());
                write_reg(REG_FC_TIME,  pick_trip_time());
                write_reg(REG_SC_TIME,  pick_trip_time());
            end

            // some phases run flat out on one or both sides
            send_gap_max   = $urandom_range(1, 0) ? 16 : 0;
            sink_stall_max = $urandom_range(1, 0) ? 16 : 0;

            sent = 0;
            while (sent < 40) begin
                n_burst(sent);
            end
        end
        drain_results();
        send_gap_max   = 16;
        sink_stall_max = 16;
    endtask

    // one burst of random length, counted into the phase total
    task automatic n_burst(inout int sent);
        int n;
        n = $urandom_range(40, 4);
        run_burst(n);
        sent += n;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n                    = 1'b0;
        i_cfg_we                   = 1'b0;
        i_cfg_index                = REG_OV_LEVEL;
        i_cfg_data                 = '0;
        sample_ch.valid            = 1'b0;
        sample_ch.voltage_sample   = '0;
        sample_ch.current_u_sample = '0;
        sample_ch.current_v_sample = '0;
        sample_ch.current_w_sample = '0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_settings();
        test_full_scale();
        test_zero_trip_time();
        test_phase_order();
        test_random_settings();

        drain_results();
        // keep the clock running to catch stray result beats
        repeat (8) @(negedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // far beyond the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/vcpr_pkg.sv
rtl/vcpr_in_if.sv
rtl/vcpr_out_if.sv
rtl/vcpr_lane.sv
rtl/vcpr_merge.sv
rtl/voltage_current_protection_relay.sv
test/tb_voltage_current_protection_relay.sv
